[src/csse_pkg.sv]
// ----------------------------------------------------------------------------
// csse_pkg
// Shared types, request codes and fixed-point clamp helpers for the cubic
// spline segment evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package csse_pkg;

  localparam int DATA_W  = 32;
  localparam int WIDTH_W = 31;
  localparam int DNUM_W  = 35;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_VALUE = 2'd1;
  localparam logic [1:0] REQ_DERIV = 2'd2;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } clamp_t;

  typedef struct packed {
    logic                     deriv;
    logic                     sat;
    logic [WIDTH_W-1:0]       width;
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
  } poly_in_t;

  typedef struct packed {
    logic                     deriv;
    logic                     vsat;
    logic                     dsat;
    logic [WIDTH_W-1:0]       width;
    logic signed [DATA_W-1:0] value;
    logic signed [DNUM_W-1:0] num;
  } poly_out_t;

  function automatic clamp_t sat32(input logic signed [63:0] v);
    clamp_t r;
    r.sat = 1'b0;
    r.val = v[DATA_W-1:0];
    if (v > 64'sd2147483647) begin
      r.sat = 1'b1;
      r.val = S32_MAX;
    end else if (v < -64'sd2147483648) begin
      r.sat = 1'b1;
      r.val = S32_MIN;
    end
    return r;
  endfunction

  // Sign and clamp an unsigned quotient magnitude.
  function automatic clamp_t div_fix(input logic ovf, input logic neg,
                                     input logic [DATA_W-1:0] q);
    clamp_t r;
    r.sat = 1'b0;
    r.val = q;
    if (ovf) begin
      r.sat = 1'b1;
      r.val = neg ? S32_MIN : S32_MAX;
    end else if (!neg) begin
      if (q[DATA_W-1]) begin
        r.sat = 1'b1;
        r.val = S32_MAX;
      end
    end else begin
      if (q > 32'h80000000) begin
        r.sat = 1'b1;
        r.val = S32_MIN;
      end else begin
        r.val = ~q + 32'd1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/csse_ram.sv]
// ----------------------------------------------------------------------------
// csse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/csse_div.sv]
// ----------------------------------------------------------------------------
// csse_div
// Pipelined restoring divider: one quotient bit per stage, with overflow
// detect on the high dividend bits and a sideband that travels along.
// ----------------------------------------------------------------------------
`default_nettype none

module csse_div #(
  parameter int NUM_W  = 49,
  parameter int DEN_W  = 31,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output      logic              valid_o,
  output      logic [QUO_W-1:0]  quot_o,
  output      logic [DEN_W-1:0]  rem_o,
  output      logic              ovf_o,
  output      logic [SIDE_W-1:0] side_o
);

  localparam int HI_W = NUM_W - QUO_W;

  logic [QUO_W:0]      vld_q;
  logic [DEN_W-1:0]    rem_q  [QUO_W+1];
  logic [DEN_W-1:0]    den_q  [QUO_W+1];
  logic [QUO_W-1:0]    lo_q   [QUO_W+1];
  logic [QUO_W-1:0]    quo_q  [QUO_W+1];
  logic                ovf_q  [QUO_W+1];
  logic [SIDE_W-1:0]   side_q [QUO_W+1];

  logic [HI_W-1:0] hi;
  logic            ovf0;

  assign hi   = num_i[NUM_W-1:QUO_W];
  assign ovf0 = {{DEN_W{1'b0}}, hi} >= {{HI_W{1'b0}}, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= ovf0 ? '0 : DEN_W'(hi);
      den_q[0]  <= den_i;
      lo_q[0]   <= num_i[QUO_W-1:0];
      quo_q[0]  <= '0;
      ovf_q[0]  <= ovf0;
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_q[j], lo_q[j][QUO_W-1]};
    assign diff  = trial - {1'b0, den_q[j]};
    assign ge    = trial >= {1'b0, den_q[j]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_q[j+1]  <= {quo_q[j][QUO_W-2:0], ge};
        lo_q[j+1]   <= {lo_q[j][QUO_W-2:0], 1'b0};
        den_q[j+1]  <= den_q[j];
        ovf_q[j+1]  <= ovf_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign valid_o = vld_q[QUO_W];
  assign quot_o  = quo_q[QUO_W];
  assign rem_o   = rem_q[QUO_W];
  assign ovf_o   = ovf_q[QUO_W];
  assign side_o  = side_q[QUO_W];

endmodule

`default_nettype wire

[src/csse_poly.sv]
// ----------------------------------------------------------------------------
// csse_poly
// Seven-stage multiply and accumulate pipeline: powers of t, coefficient
// terms, the cubic value and the derivative numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module csse_poly #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire csse_pkg::poly_in_t  in_i,
  output      logic                valid_o,
  output      csse_pkg::poly_out_t out_o
);

  import csse_pkg::*;

  logic [6:0] vld_q;

  poly_in_t          s1_q, s2_q, s3_q, s4_q, s5_q, s6_q;
  logic signed [63:0] p_tt1_q, p_bt1_q, p_ct1_q;
  clamp_t            t2_2_q, bt_2_q, ct_2_q;
  logic signed [63:0] p_t3_3_q, p_ct2_3_q, p_dt2_3_q;
  logic signed [DATA_W-1:0] t2_3_q, bt_3_q, ct_3_q;
  logic              vs3_q, ds3_q;
  clamp_t            t3_4_q, ct2_4_q, dt2_4_q;
  logic signed [DATA_W-1:0] bt_4_q, ct_4_q;
  logic              vs4_q, ds4_q;
  logic signed [63:0] p_dt3_5_q;
  logic signed [DATA_W-1:0] bt_5_q, ct_5_q, ct2_5_q, dt2_5_q;
  logic              vs5_q, ds5_q;
  clamp_t            dt3_6_q;
  logic signed [DATA_W-1:0] bt_6_q, ct_6_q, ct2_6_q, dt2_6_q;
  logic              vs6_q, ds6_q;
  poly_out_t         out_q;

  logic signed [63:0]       sum7;
  logic signed [DNUM_W-1:0] num7;
  clamp_t                   val7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q    <= in_i;
      p_tt1_q <= 64'(in_i.t) * 64'(in_i.t);
      p_bt1_q <= 64'(in_i.b) * 64'(in_i.t);
      p_ct1_q <= 64'(in_i.c) * 64'(in_i.t);

      s2_q    <= s1_q;
      t2_2_q  <= sat32(p_tt1_q >>> FRAC_BITS);
      bt_2_q  <= sat32(p_bt1_q >>> FRAC_BITS);
      ct_2_q  <= sat32(p_ct1_q >>> FRAC_BITS);

      s3_q      <= s2_q;
      p_t3_3_q  <= 64'(t2_2_q.val) * 64'(s2_q.t);
      p_ct2_3_q <= 64'(s2_q.c) * 64'(t2_2_q.val);
      p_dt2_3_q <= 64'(s2_q.d) * 64'(t2_2_q.val);
      t2_3_q    <= t2_2_q.val;
      bt_3_q    <= bt_2_q.val;
      ct_3_q    <= ct_2_q.val;
      vs3_q     <= s2_q.sat | t2_2_q.sat | bt_2_q.sat;
      ds3_q     <= s2_q.sat | t2_2_q.sat | ct_2_q.sat;

      s4_q    <= s3_q;
      t3_4_q  <= sat32(p_t3_3_q >>> FRAC_BITS);
      ct2_4_q <= sat32(p_ct2_3_q >>> FRAC_BITS);
      dt2_4_q <= sat32(p_dt2_3_q >>> FRAC_BITS);
      bt_4_q  <= bt_3_q;
      ct_4_q  <= ct_3_q;
      vs4_q   <= vs3_q;
      ds4_q   <= ds3_q;

      s5_q      <= s4_q;
      p_dt3_5_q <= 64'(s4_q.d) * 64'(t3_4_q.val);
      bt_5_q    <= bt_4_q;
      ct_5_q    <= ct_4_q;
      ct2_5_q   <= ct2_4_q.val;
      dt2_5_q   <= dt2_4_q.val;
      vs5_q     <= vs4_q | t3_4_q.sat | ct2_4_q.sat;
      ds5_q     <= ds4_q | dt2_4_q.sat;

      s6_q    <= s5_q;
      dt3_6_q <= sat32(p_dt3_5_q >>> FRAC_BITS);
      bt_6_q  <= bt_5_q;
      ct_6_q  <= ct_5_q;
      ct2_6_q <= ct2_5_q;
      dt2_6_q <= dt2_5_q;
      vs6_q   <= vs5_q;
      ds6_q   <= ds5_q;

      out_q.deriv <= s6_q.deriv;
      out_q.width <= s6_q.width;
      out_q.value <= val7.val;
      out_q.vsat  <= vs6_q | dt3_6_q.sat | val7.sat;
      out_q.dsat  <= ds6_q;
      out_q.num   <= num7;
    end
  end

  assign sum7 = 64'(s6_q.a) + 64'(bt_6_q) + 64'(ct2_6_q) + 64'(dt3_6_q.val);
  assign val7 = sat32(sum7);
  assign num7 = DNUM_W'(s6_q.b) + (DNUM_W'(ct_6_q) <<< 1)
              + DNUM_W'(dt2_6_q) * 35'sd3;

  assign valid_o = vld_q[6];
  assign out_o   = out_q;

endmodule

`default_nettype wire

[src/cubic_spline_segment_evaluator_unit.sv]
// Pipeline: three 33-stage dividers for wrap, t and derivative, plus 15
//   stages of search, table read and multiply. Throughput: one query per
//   cycle while m_axis_tready does not stall the output; a write waits
//   until no query is in flight. Reset clears control and registers
//   (knot_count 2, wrap_period 1.0); segment tables are not cleared.
// ----------------------------------------------------------------------------
// cubic_spline_segment_evaluator_unit
// Top level: stream ports, APB registers, knot search, segment table and
// the pipelined evaluation datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_spline_segment_evaluator_unit #(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // seg_index[5:0], knot_start[37:6], seg_width[68:38], coef_a[100:69],
  // coef_b[132:101], coef_c[164:133], coef_d[196:165], query_x[228:197]
  input  wire logic [231:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_value[31:0]
  output      logic [31:0]  m_axis_tdata,
  // is_derivative[0], saturated[1]
  output      logic [1:0]   m_axis_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output      logic [31:0]  prdata,
  output      logic         pready
);

  import csse_pkg::*;

  localparam int IDX_W    = $clog2(MAX_KNOTS);
  localparam int GT_W     = MAX_KNOTS - 1;
  localparam int CNT_W    = ($clog2(MAX_KNOTS + 1) > 7) ? $clog2(MAX_KNOTS + 1) : 7;
  localparam int QUO_W    = 32;
  localparam int MNUM_W   = 33;
  localparam int TNUM_W   = 33 + FRAC_BITS;
  localparam int DNUMF_W  = DNUM_W + FRAC_BITS;
  localparam int RAM_W    = WIDTH_W + 5 * DATA_W;
  localparam int FLIGHT_W = 8;
  localparam int MSIDE_W  = 1 + DATA_W;
  localparam int TSIDE_W  = 2 + WIDTH_W + 4 * DATA_W;
  localparam int DSIDE_W  = 4 + DATA_W;

  localparam logic REG_KNOT_COUNT = 1'b0;
  localparam logic REG_WRAP       = 1'b1;

  // input fields
  logic [1:0]               req;
  logic [5:0]               seg_idx;
  logic signed [DATA_W-1:0] knot_in, a_in, b_in, c_in, d_in, x_in;
  logic [WIDTH_W-1:0]       width_in;

  assign req      = s_axis_tuser;
  assign seg_idx  = s_axis_tdata[5:0];
  assign knot_in  = s_axis_tdata[37:6];
  assign width_in = s_axis_tdata[68:38];
  assign a_in     = s_axis_tdata[100:69];
  assign b_in     = s_axis_tdata[132:101];
  assign c_in     = s_axis_tdata[164:133];
  assign d_in     = s_axis_tdata[196:165];
  assign x_in     = s_axis_tdata[228:197];

  // control
  logic                en, acc, wr_acc, wr_ok, q_acc, out_hs, busy;
  logic [FLIGHT_W-1:0] flight_q, flight_d;
  logic                out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign busy          = flight_q != '0;
  assign s_axis_tready = en && !(req == REQ_WRITE && busy);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign wr_acc        = acc && req == REQ_WRITE;
  assign wr_ok         = wr_acc && (32'(seg_idx) < 32'(MAX_KNOTS));
  assign q_acc         = acc && (req == REQ_VALUE || req == REQ_DERIV);
  assign out_hs        = out_vld_q && m_axis_tready;

  always_comb begin
    flight_d = flight_q;
    if (q_acc) begin
      flight_d = flight_d + FLIGHT_W'(1);
    end
    if (out_hs) begin
      flight_d = flight_d - FLIGHT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else begin
      flight_q <= flight_d;
    end
  end

  // configuration registers
  logic [6:0]         knot_count_q;
  logic [WIDTH_W-1:0] wrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q <= 7'd2;
      wrap_q       <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_KNOT_COUNT) begin
        knot_count_q <= pwdata[6:0];
      end else begin
        wrap_q <= pwdata[WIDTH_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_WRAP) ? {1'b0, wrap_q} : {25'd0, knot_count_q};
  assign pready = 1'b1;

  logic [CNT_W-1:0] kc, n_eff;

  assign kc = CNT_W'(knot_count_q);

  always_comb begin
    n_eff = kc;
    if (kc < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (kc > CNT_W'(MAX_KNOTS)) begin
      n_eff = CNT_W'(MAX_KNOTS);
    end
  end

  // knot copies for the parallel search
  logic signed [DATA_W-1:0] knot_q [MAX_KNOTS];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_KNOTS; k++) begin
      if (wr_ok && 32'(seg_idx) == k) begin
        knot_q[k] <= knot_in;
      end
    end
  end

  // wrap: truncated remainder against the period
  logic [MNUM_W-1:0]        mod_num;
  logic [DATA_W-1:0]        x_mag;
  logic                     mod_vld;
  logic [WIDTH_W-1:0]       mod_rem;
  logic [MSIDE_W-1:0]       mod_side;
  logic signed [DATA_W-1:0] mod_x, xw;

  assign x_mag   = x_in[DATA_W-1] ? (~x_in + 32'd1) : x_in;
  assign mod_num = {1'b0, x_mag};

  csse_div #(
    .NUM_W (MNUM_W),
    .DEN_W (WIDTH_W),
    .QUO_W (QUO_W),
    .SIDE_W(MSIDE_W)
  ) u_mod_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(q_acc),
    .num_i  (mod_num),
    .den_i  (wrap_q),
    .side_i ({req == REQ_DERIV, x_in}),
    .valid_o(mod_vld),
    .quot_o (),
    .rem_o  (mod_rem),
    .ovf_o  (),
    .side_o (mod_side)
  );

  assign mod_x = mod_side[DATA_W-1:0];

  always_comb begin
    if (wrap_q == '0) begin
      xw = mod_x;
    end else if (mod_x[DATA_W-1]) begin
      xw = -DATA_W'(mod_rem);
    end else begin
      xw = DATA_W'(mod_rem);
    end
  end

  // search stages
  logic                     vld_c_q, vld_d_q, vld_e_q, vld_f_q, vld_g_q, vld_h_q;
  logic signed [DATA_W-1:0] xw_c_q, xw_d_q, xw_e_q, xw_f_q, xw_g_q;
  logic                     dv_c_q, dv_d_q, dv_e_q, dv_f_q, dv_g_q, dv_h_q;
  logic [GT_W-1:0]          gt_d_q, oh_e_q, gt_c;
  logic [IDX_W-1:0]         idx_f_q, idx_e;

  always_comb begin
    for (int j = 0; j < GT_W; j++) begin
      gt_c[j] = (32'(j) + 32'd3 <= 32'(n_eff)) && (xw_c_q > knot_q[j+1]);
    end
  end

  always_comb begin
    idx_e = '0;
    for (int j = 0; j < GT_W; j++) begin
      if (oh_e_q[j]) begin
        idx_e = idx_e | IDX_W'(j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
      vld_f_q <= 1'b0;
      vld_g_q <= 1'b0;
      vld_h_q <= 1'b0;
    end else if (en) begin
      vld_c_q <= mod_vld;
      vld_d_q <= vld_c_q;
      vld_e_q <= vld_d_q;
      vld_f_q <= vld_e_q;
      vld_g_q <= vld_f_q;
      vld_h_q <= vld_g_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xw_c_q  <= xw;
      dv_c_q  <= mod_side[DATA_W];
      gt_d_q  <= gt_c;
      xw_d_q  <= xw_c_q;
      dv_d_q  <= dv_c_q;
      oh_e_q  <= ~gt_d_q & (gt_d_q + GT_W'(1));
      xw_e_q  <= xw_d_q;
      dv_e_q  <= dv_d_q;
      idx_f_q <= idx_e;
      xw_f_q  <= xw_e_q;
      dv_f_q  <= dv_e_q;
      xw_g_q  <= xw_f_q;
      dv_g_q  <= dv_f_q;
    end
  end

  // segment table
  logic [RAM_W-1:0] ram_rd;

  csse_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_KNOTS)
  ) u_seg_ram (
    .clk_i  (clk_i),
    .we_i   (wr_ok),
    .waddr_i(IDX_W'(seg_idx)),
    .wdata_i({d_in, c_in, b_in, a_in, width_in, knot_in}),
    .re_i   (en),
    .raddr_i(idx_f_q),
    .rdata_o(ram_rd)
  );

  // offset from the knot
  logic signed [32:0]       diff_h_q;
  logic [WIDTH_W-1:0]       w_h_q;
  logic signed [DATA_W-1:0] a_h_q, b_h_q, c_h_q, d_h_q;
  logic [32:0]              diff_mag;

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_h_q <= 33'(xw_g_q) - 33'($signed(ram_rd[31:0]));
      w_h_q    <= ram_rd[62:32];
      a_h_q    <= ram_rd[94:63];
      b_h_q    <= ram_rd[126:95];
      c_h_q    <= ram_rd[158:127];
      d_h_q    <= ram_rd[190:159];
      dv_h_q   <= dv_g_q;
    end
  end

  assign diff_mag = diff_h_q[32] ? (~diff_h_q + 33'd1) : diff_h_q;

  // t = offset / width
  logic               t_vld;
  logic [QUO_W-1:0]   t_quot;
  logic               t_ovf;
  logic [TSIDE_W-1:0] t_side;
  clamp_t             t_fix;
  poly_in_t           pin_q;
  logic               pin_vld_q;

  csse_div #(
    .NUM_W (TNUM_W),
    .DEN_W (WIDTH_W),
    .QUO_W (QUO_W),
    .SIDE_W(TSIDE_W)
  ) u_t_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vld_h_q),
    .num_i  ({diff_mag, {FRAC_BITS{1'b0}}}),
    .den_i  (w_h_q),
    .side_i ({dv_h_q, diff_h_q[32], w_h_q, a_h_q, b_h_q, c_h_q, d_h_q}),
    .valid_o(t_vld),
    .quot_o (t_quot),
    .rem_o  (),
    .ovf_o  (t_ovf),
    .side_o (t_side)
  );

  assign t_fix = div_fix(t_ovf, t_side[TSIDE_W-2], t_quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_vld_q <= 1'b0;
    end else if (en) begin
      pin_vld_q <= t_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pin_q.deriv <= t_side[TSIDE_W-1];
      pin_q.sat   <= t_fix.sat;
      pin_q.t     <= t_fix.val;
      pin_q.width <= t_side[4*DATA_W +: WIDTH_W];
      pin_q.a     <= t_side[3*DATA_W +: DATA_W];
      pin_q.b     <= t_side[2*DATA_W +: DATA_W];
      pin_q.c     <= t_side[DATA_W +: DATA_W];
      pin_q.d     <= t_side[DATA_W-1:0];
    end
  end

  // polynomial
  logic      po_vld;
  poly_out_t po;

  csse_poly #(
    .FRAC_BITS(FRAC_BITS)
  ) u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(pin_vld_q),
    .in_i   (pin_q),
    .valid_o(po_vld),
    .out_o  (po)
  );

  // derivative numerator / width
  logic [DNUM_W-1:0]  num_mag;
  logic               d_vld;
  logic [QUO_W-1:0]   d_quot;
  logic               d_ovf;
  logic [DSIDE_W-1:0] d_side;
  clamp_t             d_fix;

  assign num_mag = po.num[DNUM_W-1] ? (~po.num + DNUM_W'(1)) : po.num;

  csse_div #(
    .NUM_W (DNUMF_W),
    .DEN_W (WIDTH_W),
    .QUO_W (QUO_W),
    .SIDE_W(DSIDE_W)
  ) u_d_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(po_vld),
    .num_i  ({num_mag, {FRAC_BITS{1'b0}}}),
    .den_i  (po.width),
    .side_i ({po.deriv, po.num[DNUM_W-1], po.vsat, po.dsat, po.value}),
    .valid_o(d_vld),
    .quot_o (d_quot),
    .rem_o  (),
    .ovf_o  (d_ovf),
    .side_o (d_side)
  );

  assign d_fix = div_fix(d_ovf, d_side[DATA_W+2], d_quot);

  // output register
  logic [DATA_W-1:0] res_q;
  logic              dv_o_q, sat_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && d_vld) begin
      dv_o_q <= d_side[DATA_W+3];
      if (d_side[DATA_W+3]) begin
        res_q   <= d_fix.val;
        sat_o_q <= d_side[DATA_W] | d_fix.sat;
      end else begin
        res_q   <= d_side[DATA_W-1:0];
        sat_o_q <= d_side[DATA_W+1];
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = {sat_o_q, dv_o_q};

endmodule

`default_nettype wire
